/* rtl/smoothstep_breakpoint_envelope_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef SMOOTHSTEP_BREAKPOINT_ENVELOPE_CORE_DEFINES_SVH
`define SMOOTHSTEP_BREAKPOINT_ENVELOPE_CORE_DEFINES_SVH

// Check on every clock edge outside reset.
`define SBE_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define SBE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sbe_pkg.sv */
`default_nettype none
package sbe_pkg;

    localparam int CMD_W      = 2;
    localparam int POS_W      = 17;
    localparam int VAL_W      = 16;
    localparam int FRAC_W     = 16;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_STEPS  = POS_W;
    localparam int DSTEP_W    = $clog2(DIV_STEPS + 1);

    localparam int TT_W       = 2 * POS_W - 1;
    localparam int K_W        = POS_W + 1;
    localparam int PM_W       = TT_W + K_W;
    localparam int S_W        = TT_W;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int PROD_W     = S_W + 1 + DIFF_W;
    localparam int ENV_SHIFT  = 2 * FRAC_W;
    localparam int SUM_W      = PROD_W - ENV_SHIFT;

    localparam logic [POS_W-1:0] T_ONE    = POS_W'(1 << FRAC_W);
    localparam logic [K_W-1:0]   SMOOTH_K = K_W'(3 * (1 << FRAC_W));

    localparam logic [CMD_W-1:0] CMD_CLEAR  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_APPEND = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_QUERY  = CMD_W'(2);

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY,
        OP_NOP
    } sbe_op_t;

    typedef struct packed {
        sbe_op_t                  op;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  point_value;
    } sbe_task_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
        logic [POS_W-1:0] divisor;
    } sbe_div_req_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quotient;
    } sbe_div_rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_FIRST,
        BK_CHK0,
        BK_SCAN,
        BK_DIV,
        BK_MUL_S,
        BK_MUL_D,
        BK_SUM,
        BK_DONE
    } sbe_back_state_t;

endpackage
`default_nettype wire

/* rtl/sbe_in_if.sv */
`default_nettype none
interface sbe_in_if
    import sbe_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] point_value;

    modport source (output valid, cmd, position, point_value, input ready);
    modport sink (input valid, cmd, position, point_value, output ready);
endinterface
`default_nettype wire

/* rtl/sbe_out_if.sv */
`default_nettype none
interface sbe_out_if
    import sbe_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] envelope_value;
    logic                    status;

    modport source (output valid, envelope_value, status, input ready);
    modport sink (input valid, envelope_value, status, output ready);
endinterface
`default_nettype wire

/* rtl/sbe_front.sv */
`default_nettype none
module sbe_front
    import sbe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sbe_in_if.sink     item,
    output sbe_task_t  push_word,
    output logic       push_valid,
    input  wire logic  push_ready
);

    logic      hold_valid_reg;
    logic      hold_valid_next;
    sbe_task_t hold_reg;
    logic      accept;

    function automatic sbe_op_t classify(input logic [CMD_W-1:0] cmd);
        sbe_op_t op;
        case (cmd)
            CMD_CLEAR:  op = OP_CLEAR;
            CMD_APPEND: op = OP_APPEND;
            CMD_QUERY:  op = OP_QUERY;
            default:    op = OP_NOP;
        endcase
        return op;
    endfunction

    assign item.ready = !hold_valid_reg || push_ready;
    assign accept     = item.valid && item.ready;
    assign push_valid = hold_valid_reg;
    assign push_word  = hold_reg;

    always_comb
    begin
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg.op          <= classify(item.cmd);
            hold_reg.position    <= item.position;
            hold_reg.point_value <= item.point_value;
        end
    end

endmodule
`default_nettype wire

/* rtl/sbe_fifo.sv */
`default_nettype none
module sbe_fifo
    import sbe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire sbe_task_t  push_word,
    input  wire logic       push_valid,
    output logic            push_ready,
    output sbe_task_t       pop_word,
    output logic            pop_valid,
    input  wire logic       pop_ready
);

    sbe_task_t           slot_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] ptr);
        logic [QPTR_W-1:0] res;
        if (ptr == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = ptr + QPTR_W'(1);
        end
        return res;
    endfunction

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = slot_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

/* rtl/sbe_div.sv */
`default_nettype none
module sbe_div
    import sbe_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sbe_div_req_t  req,
    output sbe_div_rsp_t       rsp
);

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [DSTEP_W-1:0]  step_reg;
    logic [DSTEP_W-1:0]  step_next;
    logic [POS_W:0]      rem_reg;
    logic [POS_W-1:0]    den_reg;
    logic [POS_W-1:0]    quo_reg;
    logic                ge;
    logic [POS_W:0]      rem_sub;
    logic [POS_W:0]      rem_shift;
    logic [POS_W-1:0]    quo_shift;

    always_comb
    begin
        ge        = (rem_reg >= {1'b0, den_reg});
        rem_sub   = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_shift = {rem_sub[POS_W-1:0], 1'b0};
        quo_shift = {quo_reg[POS_W-2:0], ge};
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = DSTEP_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            step_next = step_reg - DSTEP_W'(1);
            if (step_reg == DSTEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {1'b0, req.dividend};
            den_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_shift;
            quo_reg <= quo_shift;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

/* rtl/sbe_back.sv */
`default_nettype none
module sbe_back
    import sbe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire sbe_task_t  task_word,
    input  wire logic       task_valid,
    output logic            task_ready,
    sbe_out_if.source       result
);

    sbe_back_state_t  state_reg;
    sbe_back_state_t  state_next;

    logic [POS_W-1:0]         pos_mem [MAX_POINTS];
    logic signed [VAL_W-1:0]  val_mem [MAX_POINTS];

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         count_m1;
    logic                     full;
    logic [IDX_W-1:0]         last_idx;
    logic [IDX_W-1:0]         rd_addr;
    logic                     mem_we;

    logic [POS_W-1:0]         rd_pos_reg;
    logic signed [VAL_W-1:0]  rd_val_reg;
    logic [POS_W-1:0]         q_reg;
    logic [POS_W-1:0]         lp_reg;
    logic signed [VAL_W-1:0]  lv_reg;
    logic [POS_W-1:0]         pa_reg;
    logic signed [VAL_W-1:0]  va_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [TT_W-1:0]          tt_reg;
    logic [K_W-1:0]           k_reg;
    logic [S_W-1:0]           s_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  res_env_reg;
    logic                     res_status_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [VAL_W-1:0]  out_env_reg;
    logic                     out_status_reg;
    logic                     out_free;
    logic                     load_out;

    logic                     take;
    logic                     hit;
    logic                     edge_lo;
    logic                     edge_hi;
    sbe_div_req_t             div_req;
    sbe_div_rsp_t             div_rsp;

    logic [POS_W-1:0]         t_sat;
    logic [TT_W-1:0]          t_ext;
    logic [PM_W-1:0]          mul_full;
    logic signed [SUM_W-1:0]  term;
    logic                     round_up;
    logic signed [SUM_W-1:0]  env_sum;

    sbe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign count_m1 = count_reg - CNT_W'(1);
    assign last_idx = count_m1[IDX_W-1:0];
    assign full     = (count_reg == CNT_W'(MAX_POINTS));
    assign take     = task_valid && (state_reg == BK_IDLE);
    assign hit      = (q_reg <= rd_pos_reg);
    assign edge_lo  = (q_reg <= rd_pos_reg);
    assign edge_hi  = (q_reg >= lp_reg);
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (task_valid)
                begin
                    if (task_word.op == OP_QUERY && count_reg != '0)
                    begin
                        state_next = BK_FIRST;
                    end
                    else
                    begin
                        state_next = BK_DONE;
                    end
                end
            end
            BK_FIRST: state_next = BK_CHK0;
            BK_CHK0:
            begin
                if (edge_lo || edge_hi)
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (hit)
                begin
                    state_next = BK_DIV;
                end
                else if (idx_reg == last_idx)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = BK_MUL_S;
                end
            end
            BK_MUL_S: state_next = BK_MUL_D;
            BK_MUL_D: state_next = BK_SUM;
            BK_SUM:   state_next = BK_DONE;
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        task_ready       = 1'b0;
        rd_addr          = '0;
        mem_we           = 1'b0;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = q_reg - pa_reg;
        div_req.divisor  = rd_pos_reg - pa_reg;
        case (state_reg)
            BK_IDLE:
            begin
                task_ready = 1'b1;
                rd_addr    = last_idx;
                mem_we     = task_valid && (task_word.op == OP_APPEND) && !full;
            end
            BK_FIRST: rd_addr = '0;
            BK_CHK0:  rd_addr = IDX_W'(1);
            BK_SCAN:
            begin
                rd_addr       = idx_reg + IDX_W'(1);
                div_req.start = hit;
            end
            BK_DONE:  load_out = out_free;
            default:  rd_addr = '0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (take && task_word.op == OP_CLEAR)
        begin
            count_next = '0;
        end
        else if (mem_we)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        t_sat    = (div_rsp.quotient > T_ONE) ? T_ONE : div_rsp.quotient;
        t_ext    = TT_W'(t_sat);
        mul_full = PM_W'(tt_reg) * PM_W'(k_reg);
        term     = $signed(prod_reg[PROD_W-1:ENV_SHIFT]);
        round_up = prod_reg[PROD_W-1] && (|prod_reg[ENV_SHIFT-1:0]);
        env_sum  = SUM_W'(va_reg) + term + SUM_W'({1'b0, round_up});
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg <= pos_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
        if (mem_we)
        begin
            pos_mem[count_reg[IDX_W-1:0]] <= task_word.position;
            val_mem[count_reg[IDX_W-1:0]] <= task_word.point_value;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                q_reg          <= task_word.position;
                res_env_reg    <= '0;
                res_status_reg <= (task_word.op == OP_APPEND) && full;
            end
            BK_FIRST:
            begin
                lp_reg <= rd_pos_reg;
                lv_reg <= rd_val_reg;
            end
            BK_CHK0:
            begin
                if (edge_lo)
                begin
                    res_env_reg <= rd_val_reg;
                end
                else
                begin
                    res_env_reg <= lv_reg;
                end
                pa_reg  <= rd_pos_reg;
                va_reg  <= rd_val_reg;
                idx_reg <= IDX_W'(1);
            end
            BK_SCAN:
            begin
                if (hit)
                begin
                    diff_reg <= DIFF_W'(rd_val_reg) - DIFF_W'(va_reg);
                end
                else
                begin
                    res_env_reg <= lv_reg;
                    pa_reg      <= rd_pos_reg;
                    va_reg      <= rd_val_reg;
                    idx_reg     <= idx_reg + IDX_W'(1);
                end
            end
            BK_DIV:
            begin
                tt_reg <= t_ext * t_ext;
                k_reg  <= SMOOTH_K - (K_W'(t_sat) << 1);
            end
            BK_MUL_S: s_reg <= mul_full[FRAC_W +: S_W];
            BK_MUL_D: prod_reg <= PROD_W'($signed({1'b0, s_reg})) * PROD_W'(diff_reg);
            BK_SUM:   res_env_reg <= env_sum[VAL_W-1:0];
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_env_reg    <= res_env_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.envelope_value = out_env_reg;
    assign result.status         = out_status_reg;

endmodule
`default_nettype wire

/* rtl/smoothstep_breakpoint_envelope_core.sv */
// Breakpoint envelope with smoothstep easing between points.
// item channel: one word per command (cmd, position, point_value). cmd clear
// empties the table, append stores a breakpoint (up to 16), query reads the
// envelope at position. An unused cmd code is answered with zero.
// result channel: exactly one word per item, in order. envelope_value holds
// the eased value for a query and zero otherwise; status is 1 when an append
// finds the table full.
// A registered input stage feeds a two-word queue; the execution unit takes
// one word at a time and takes the next word the cycle after its result
// loads. A query between points scans the breakpoints and then divides: the
// breakpoint memory gives one entry per cycle and the divider produces one
// quotient bit per cycle over 17 steps, followed by two multiply stages and
// a sum.
// Reset empties the table and the queue and drops result valid; breakpoint
// storage keeps no reset value. A stalled result holds in the output register
// while the input stage and queue keep taking words until the queue fills.
`default_nettype none
module smoothstep_breakpoint_envelope_core
    import sbe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sbe_in_if.sink     item,
    sbe_out_if.source  result
);

    sbe_task_t  front_word;
    logic       front_valid;
    logic       front_ready;
    sbe_task_t  queue_word;
    logic       queue_valid;
    logic       queue_ready;

    sbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_word  (front_word),
        .push_valid (front_valid),
        .push_ready (front_ready)
    );

    sbe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_word  (front_word),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_word   (queue_word),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    sbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_word  (queue_word),
        .task_valid (queue_valid),
        .task_ready (queue_ready),
        .result     (result)
    );

endmodule
`default_nettype wire

/* rtl/sbe_checker.sv */
`default_nettype none
`include "smoothstep_breakpoint_envelope_core_defines.svh"
module sbe_checker
    import sbe_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    result_valid,
    input wire logic                    result_ready,
    input wire logic signed [VAL_W-1:0] envelope_value,
    input wire logic                    status
);

    `SBE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !result_valid, "result valid in reset")

    `SBE_ASSERT_RUN(a_valid_hold, result_valid && !result_ready |=> result_valid, "word dropped")

    `SBE_ASSERT_RUN(a_data_hold, result_valid && !result_ready |=> $stable(envelope_value) && $stable(status), "stalled word changed")

    `SBE_ASSERT_RUN(a_reject_zero, result_valid && status |-> envelope_value == '0, "rejected append with value")

endmodule

bind smoothstep_breakpoint_envelope_core sbe_checker u_sbe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .envelope_value (result.envelope_value),
    .status         (result.status)
);
`default_nettype wire
